FILE: design/prv_pkg.sv
// Shared types, codes and constants of the path record validator.
package prv_pkg;

  localparam int FRAC_BITS_DEF = 24;
  localparam int EXT_W         = 19;
  localparam int CFG_IDX_W     = 1;
  localparam int NUM_LANES     = 6;
  localparam int PX_W          = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'd1;

  localparam logic [EXT_W-1:0] EXT_RESET = 19'd1;

  localparam logic [15:0] SEL_SUB_CLOSED    = 16'd0;
  localparam logic [15:0] SEL_KNOT_SMOOTH_C = 16'd1;
  localparam logic [15:0] SEL_KNOT_CORNER_C = 16'd2;
  localparam logic [15:0] SEL_SUB_OPEN      = 16'd3;
  localparam logic [15:0] SEL_KNOT_SMOOTH_O = 16'd4;
  localparam logic [15:0] SEL_KNOT_CORNER_O = 16'd5;
  localparam logic [15:0] SEL_FILL_RULE     = 16'd6;
  localparam logic [15:0] SEL_CLIPBOARD     = 16'd7;
  localparam logic [15:0] SEL_INIT_FILL     = 16'd8;

  localparam logic [15:0] MAX_OP = 16'd3;

  localparam logic [2:0] KIND_FILL_RULE = 3'd0;
  localparam logic [2:0] KIND_INIT_FILL = 3'd1;
  localparam logic [2:0] KIND_SUBPATH   = 3'd2;
  localparam logic [2:0] KIND_KNOT      = 3'd3;
  localparam logic [2:0] KIND_CLIPBOARD = 3'd4;
  localparam logic [2:0] KIND_ERROR     = 3'd5;

  typedef struct packed {
    logic [15:0] selector;
    logic [31:0] word0;
    logic [31:0] word1;
    logic [31:0] word2;
    logic [31:0] word3;
    logic [31:0] word4;
    logic [31:0] word5;
    logic        last_record;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]         record_kind;
    logic [15:0]        header_value;
    logic               kind_flag;
    logic [1:0]         combine_op;
    logic signed [31:0] group_id;
    logic signed [31:0] in_y_px;
    logic signed [31:0] in_x_px;
    logic signed [31:0] anchor_y_px;
    logic signed [31:0] anchor_x_px;
    logic signed [31:0] out_y_px;
    logic signed [31:0] out_x_px;
    logic               path_valid;
  } out_beat_t;

  typedef struct packed {
    logic [2:0]         record_kind;
    logic [15:0]        header_value;
    logic               kind_flag;
    logic [1:0]         combine_op;
    logic signed [31:0] group_id;
    logic               path_valid;
  } info_t;

endpackage

FILE: design/prv_ctrl.sv
// Record classification and the path state that checks subpath and knot order.
module prv_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  prv_pkg::in_beat_t beat,
  output prv_pkg::info_t    info
);

  logic        open_r, open_nxt;
  logic [15:0] exp_r, exp_nxt;
  logic [15:0] seen_r, seen_nxt;
  logic        failed_r, failed_nxt;
  logic [15:0] hi;
  logic [15:0] op;

  assign hi = beat.word0[31:16];
  assign op = beat.word0[15:0];

  always_comb begin
    info       = '0;
    open_nxt   = open_r;
    exp_nxt    = exp_r;
    seen_nxt   = seen_r;
    failed_nxt = failed_r;
    if (!failed_r) begin
      unique case (beat.selector)
        prv_pkg::SEL_FILL_RULE, prv_pkg::SEL_INIT_FILL: begin
          info.record_kind  = (beat.selector == prv_pkg::SEL_FILL_RULE) ?
                              prv_pkg::KIND_FILL_RULE : prv_pkg::KIND_INIT_FILL;
          info.header_value = hi;
        end
        prv_pkg::SEL_SUB_CLOSED, prv_pkg::SEL_SUB_OPEN: begin
          if ((open_r && (seen_r != exp_r)) || (op > prv_pkg::MAX_OP)) begin
            failed_nxt = 1'b1;
          end else begin
            open_nxt          = 1'b1;
            exp_nxt           = hi;
            seen_nxt          = '0;
            info.record_kind  = prv_pkg::KIND_SUBPATH;
            info.header_value = hi;
            info.kind_flag    = (beat.selector == prv_pkg::SEL_SUB_CLOSED);
            info.combine_op   = op[1:0];
            info.group_id     = {beat.word2[15:0], beat.word3[31:16]};
          end
        end
        prv_pkg::SEL_KNOT_SMOOTH_C, prv_pkg::SEL_KNOT_CORNER_C,
        prv_pkg::SEL_KNOT_SMOOTH_O, prv_pkg::SEL_KNOT_CORNER_O: begin
          if (!open_r || (seen_r >= exp_r)) begin
            failed_nxt = 1'b1;
          end else begin
            seen_nxt         = seen_r + 16'd1;
            info.record_kind = prv_pkg::KIND_KNOT;
            info.kind_flag   = (beat.selector == prv_pkg::SEL_KNOT_SMOOTH_C) ||
                               (beat.selector == prv_pkg::SEL_KNOT_SMOOTH_O);
          end
        end
        prv_pkg::SEL_CLIPBOARD: begin
          info.record_kind = prv_pkg::KIND_CLIPBOARD;
        end
        default: begin
          failed_nxt = 1'b1;
        end
      endcase
    end
    if (failed_nxt) begin
      info             = '0;
      info.record_kind = prv_pkg::KIND_ERROR;
    end
    if (beat.last_record) begin
      info.path_valid = !failed_nxt && !(open_nxt && (seen_nxt != exp_nxt));
      open_nxt        = 1'b0;
      exp_nxt         = '0;
      seen_nxt        = '0;
      failed_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r   <= 1'b0;
      exp_r    <= '0;
      seen_r   <= '0;
      failed_r <= 1'b0;
    end else if (fire) begin
      open_r   <= open_nxt;
      exp_r    <= exp_nxt;
      seen_r   <= seen_nxt;
      failed_r <= failed_nxt;
    end
  end

endmodule

FILE: design/prv_lane.sv
// One coordinate lane: fraction times canvas extent, then rounding and saturation.
module prv_lane #(
  parameter int FRAC_BITS = prv_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             load,
  input  logic [31:0]                      word,
  input  logic [prv_pkg::EXT_W-1:0]        extent,
  output logic signed [prv_pkg::PX_W-1:0]  px
);

  localparam int PW = 32 + prv_pkg::EXT_W + 1;
  localparam int S  = FRAC_BITS - 8;
  localparam logic signed [PW-1:0] RND = (PW'(1) << S) >> 1;

  logic signed [PW-1:0] prod_nxt;
  logic signed [PW-1:0] prod_r;
  logic signed [PW-1:0] shifted;
  logic [PW-32:0]       top_bits;

  assign prod_nxt = PW'(signed'(word)) * PW'(signed'({1'b0, extent}));

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_nxt;
    end
  end

  assign shifted  = (prod_r + RND) >>> S;
  assign top_bits = shifted[PW-1:31];

  always_comb begin
    if ((&top_bits) || !(|top_bits)) begin
      px = shifted[31:0];
    end else if (shifted[PW-1]) begin
      px = 32'sh8000_0000;
    end else begin
      px = 32'sh7FFF_FFFF;
    end
  end

endmodule

FILE: design/prv_merge.sv
// Output stage: joins the record summary with the lane coordinates into one result beat.
module prv_merge (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             in_valid,
  output logic                                             in_ready,
  input  prv_pkg::info_t                                   info,
  input  logic [prv_pkg::NUM_LANES-1:0][prv_pkg::PX_W-1:0] px,
  output logic                                             out_valid,
  input  logic                                             out_ready,
  output prv_pkg::out_beat_t                               out_data
);

  logic                        out_valid_r;
  prv_pkg::out_beat_t          out_data_r, out_data_nxt;
  logic                        knot;
  logic [prv_pkg::NUM_LANES-1:0][prv_pkg::PX_W-1:0] px_sel;

  assign in_ready = !out_valid_r || out_ready;
  assign knot     = (info.record_kind == prv_pkg::KIND_KNOT);
  assign px_sel   = knot ? px : '0;

  always_comb begin
    out_data_nxt              = '0;
    out_data_nxt.record_kind  = info.record_kind;
    out_data_nxt.header_value = info.header_value;
    out_data_nxt.kind_flag    = info.kind_flag;
    out_data_nxt.combine_op   = info.combine_op;
    out_data_nxt.group_id     = info.group_id;
    out_data_nxt.in_y_px      = px_sel[0];
    out_data_nxt.in_x_px      = px_sel[1];
    out_data_nxt.anchor_y_px  = px_sel[2];
    out_data_nxt.anchor_x_px  = px_sel[3];
    out_data_nxt.out_y_px     = px_sel[4];
    out_data_nxt.out_x_px     = px_sel[5];
    out_data_nxt.path_valid   = info.path_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: design/path_record_validator_core.sv
// Top level of the path record validator: control, six scaling lanes and output stage.
//
// One 26-byte path record enters per in_ beat (selector, six words, last_record)
// and exactly one result beat leaves on out_ for it, in order. A record is
// classified and checked against the path state in the cycle it is accepted.
// Knot records have their six fractions scaled by the canvas extent in six
// parallel lanes: each lane registers its 32x19 product, then rounds and
// saturates it, and the output stage merges the lanes with the record summary.
// A record passes two registers, the lane stage and the output stage, and one
// record per cycle is sustained while the receiver keeps out_ready high. The
// configuration port writes the canvas width (index 0) and the canvas height
// (index 1); both reset to 1. Write them only while idle.
// Reset (rst_n low, synchronous) empties the pipeline and clears the path
// state. When the receiver holds out_ready low the result stays on out_data,
// one more record can still enter the lane stage, and then in_ready drops.
module path_record_validator_core #(
  parameter int FRAC_BITS = prv_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  prv_pkg::in_beat_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output prv_pkg::out_beat_t              out_data,
  input  logic                            cfg_we,
  input  logic [prv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [prv_pkg::EXT_W-1:0]       cfg_wdata
);

  logic                          in_fire;
  logic                          mrg_ready;
  logic                          s1_v_r;
  prv_pkg::info_t                info_nxt;
  prv_pkg::info_t                s1_info_r;
  logic [prv_pkg::EXT_W-1:0]     width_r;
  logic [prv_pkg::EXT_W-1:0]     height_r;
  logic [prv_pkg::NUM_LANES-1:0][31:0]               lane_word;
  logic [prv_pkg::NUM_LANES-1:0][prv_pkg::EXT_W-1:0] lane_ext;
  logic [prv_pkg::NUM_LANES-1:0][prv_pkg::PX_W-1:0]  lane_px;

  assign in_ready = !s1_v_r || mrg_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= prv_pkg::EXT_RESET;
      height_r <= prv_pkg::EXT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        prv_pkg::CFG_IDX_WIDTH:  width_r  <= cfg_wdata;
        prv_pkg::CFG_IDX_HEIGHT: height_r <= cfg_wdata;
      endcase
    end
  end

  prv_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (in_fire),
    .beat  (in_data),
    .info  (info_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_info_r <= info_nxt;
    end
  end

  assign lane_word[0] = in_data.word0;
  assign lane_word[1] = in_data.word1;
  assign lane_word[2] = in_data.word2;
  assign lane_word[3] = in_data.word3;
  assign lane_word[4] = in_data.word4;
  assign lane_word[5] = in_data.word5;

  for (genvar g = 0; g < prv_pkg::NUM_LANES; g++) begin : g_lane
    assign lane_ext[g] = (g % 2 == 0) ? height_r : width_r;

    prv_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .load   (in_fire),
      .word   (lane_word[g]),
      .extent (lane_ext[g]),
      .px     (lane_px[g])
    );
  end

  prv_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_v_r),
    .in_ready  (mrg_ready),
    .info      (s1_info_r),
    .px        (lane_px),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: design/prv_checker.sv
// Port-level checks of the path record validator and their attachment to the top level.
module prv_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input prv_pkg::out_beat_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Result beat changed while stalled.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result beat shown right after reset.");

  a_px_only_knot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.record_kind != prv_pkg::KIND_KNOT) |->
      (out_data.in_y_px == 0) && (out_data.in_x_px == 0) &&
      (out_data.anchor_y_px == 0) && (out_data.anchor_x_px == 0) &&
      (out_data.out_y_px == 0) && (out_data.out_x_px == 0))
    else $error("Coordinates on a beat that is not a knot.");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.record_kind == prv_pkg::KIND_ERROR) |->
      !out_data.path_valid && (out_data.header_value == 0) &&
      !out_data.kind_flag && (out_data.combine_op == 0) &&
      (out_data.group_id == 0))
    else $error("Error beat carries record fields or a valid path.");

endmodule

bind path_record_validator_core prv_checker u_prv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
